>>> rtl/core/ibt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_pkg: shared types and constants for the balanced ternary converter
// Word widths, trit codes and the command handed from the front to the back.
// ----------------------------------------------------------------------------
package ibt_pkg;

    localparam int WORD_W      = 64;               // input integer width
    localparam int LEN_W       = 7;                // trit count width
    localparam int TRIT_W      = 2;                // signed trit width
    localparam int CHUNK_W     = 8;                // dividend bits per divide cycle
    localparam int NCHUNK      = WORD_W / CHUNK_W; // dividend chunks per digit
    localparam int CHUNK_CNT_W = $clog2(NCHUNK);
    localparam int IN_DATA_W   = ((WORD_W + LEN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((TRIT_W + 7) / 8) * 8;
    localparam int CMD_DEPTH   = 2;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);

    // Any 64-bit magnitude, 2^63 included, fits in this many trits.
    localparam logic [LEN_W-1:0] NAT_MAX_TRITS = 7'd41;

    // Trit codes, two's complement
    localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'b00;
    localparam logic [TRIT_W-1:0] TRIT_POS  = 2'b01;
    localparam logic [TRIT_W-1:0] TRIT_NEG  = 2'b11;
    localparam logic [TRIT_W-1:0] TRIT_BAD  = 2'b10;

    // One classified request, front to back.
    // work holds magnitude + 1, so each digit step is floor(work / 3).
    typedef struct packed {
        logic [WORD_W-1:0] work;
        logic              neg;
        logic              fixed;
        logic [LEN_W-1:0]  count;
        logic              mag_zero;
    } t_cmd;

endpackage

>>> rtl/core/ibt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_front: request intake and classification
// Splits the sign, forms magnitude + 1, settles the trit count and drops
// requests that produce no trits.
// ----------------------------------------------------------------------------
module ibt_front #(
    parameter int MAX_TRITS = 64
) (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ibt_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  logic                          s_axis_tuser,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output ibt_pkg::t_cmd                 o_push_cmd
);

    localparam logic [ibt_pkg::LEN_W-1:0] MaxCount = ibt_pkg::LEN_W'(MAX_TRITS);

    logic [ibt_pkg::WORD_W-1:0] value;
    logic [ibt_pkg::LEN_W-1:0]  length;
    logic                       neg;
    logic                       mag_zero;
    logic                       drop;
    logic [ibt_pkg::WORD_W-1:0] addend;
    logic [ibt_pkg::WORD_W-1:0] operand;

    assign value    = s_axis_tdata[ibt_pkg::WORD_W-1:0];
    assign length   = s_axis_tdata[ibt_pkg::WORD_W +: ibt_pkg::LEN_W];
    assign neg      = value[ibt_pkg::WORD_W-1];
    assign mag_zero = (value == '0);

    // |v| + 1: v + 1 when positive, ~v + 2 when negative
    assign operand  = neg ? ~value : value;
    assign addend   = neg ? ibt_pkg::WORD_W'(2) : ibt_pkg::WORD_W'(1);

    always_comb begin
        o_push_cmd          = '0;
        o_push_cmd.work     = operand + addend;
        o_push_cmd.neg      = neg;
        o_push_cmd.fixed    = s_axis_tuser;
        o_push_cmd.mag_zero = mag_zero;
        if (s_axis_tuser) begin
            o_push_cmd.count = (length > MaxCount) ? MaxCount : length;
        end else begin
            o_push_cmd.count = MaxCount;
        end
    end

    // zero with natural length, or a fixed length of zero, yields nothing
    assign drop          = s_axis_tuser ? (length == '0) : mag_zero;
    assign o_push_valid  = s_axis_tvalid && !drop;
    assign s_axis_tready = i_push_ready;

endmodule

>>> rtl/core/ibt_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_cmd_fifo: short command queue between front and back
// Flop-based FIFO, first-word-fall-through on the read side.
// ----------------------------------------------------------------------------
module ibt_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ibt_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output ibt_pkg::t_cmd o_pop_cmd
);

    ibt_pkg::t_cmd                  r_mem [ibt_pkg::CMD_DEPTH];
    logic [ibt_pkg::CMD_PTR_W-1:0]  r_wptr;
    logic [ibt_pkg::CMD_PTR_W-1:0]  r_rptr;
    logic [ibt_pkg::CMD_CNT_W-1:0]  r_cnt;
    logic                           push;
    logic                           pop;

    assign o_push_ready = (r_cnt != ibt_pkg::CMD_CNT_W'(ibt_pkg::CMD_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_cmd    = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wptr] <= i_push_cmd;
        end
    end

endmodule

>>> rtl/core/ibt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibt_back: digit sequencer with serial divide-by-three
// Long division by 3, eight dividend bits a cycle, MSB first; quotient bits
// shift into the same register. Trits leave through a one-deep output stage.
// ----------------------------------------------------------------------------
module ibt_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_valid,
    output logic                           o_cmd_ready,
    input  ibt_pkg::t_cmd                  i_cmd,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [ibt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                           r_state, n_state;
    logic [ibt_pkg::CHUNK_CNT_W-1:0]  r_chunk, n_chunk;
    logic [ibt_pkg::WORD_W-1:0]       r_div, n_div;
    logic [1:0]                       r_rem, n_rem;
    logic                             r_zero, n_zero;
    logic                             r_neg, n_neg;
    logic                             r_fixed, n_fixed;
    logic [ibt_pkg::LEN_W-1:0]        r_count, n_count;
    logic [ibt_pkg::LEN_W-1:0]        r_sent, n_sent;
    logic [ibt_pkg::TRIT_W-1:0]       r_digit, n_digit;
    logic                             r_out_valid, n_out_valid;
    logic [ibt_pkg::TRIT_W-1:0]       r_out_trit, n_out_trit;
    logic                             r_out_last, n_out_last;

    logic [ibt_pkg::CHUNK_W-1:0]      chunk_q;
    logic [1:0]                       chunk_rem;
    logic [ibt_pkg::WORD_W-1:0]       div_shift;
    logic [ibt_pkg::TRIT_W-1:0]       mag_digit;
    logic [ibt_pkg::TRIT_W-1:0]       signed_digit;
    logic                             slot_free;
    logic                             out_last;
    logic [ibt_pkg::LEN_W-1:0]        sent_inc;

    // one chunk of long division by 3
    always_comb begin
        logic [2:0] t;
        logic [1:0] rem;
        rem     = r_rem;
        chunk_q = '0;
        for (int i = ibt_pkg::CHUNK_W - 1; i >= 0; i--) begin
            t = {rem, r_div[ibt_pkg::WORD_W - ibt_pkg::CHUNK_W + i]};
            if (t >= 3'd3) begin
                chunk_q[i] = 1'b1;
                rem        = 2'(t - 3'd3);
            end else begin
                rem        = t[1:0];
            end
        end
        chunk_rem = rem;
    end

    assign div_shift = {r_div[ibt_pkg::WORD_W-ibt_pkg::CHUNK_W-1:0], chunk_q};

    // remainder of (m + 1) mod 3: 1 -> 0, 2 -> +1, 0 -> -1
    always_comb begin
        case (chunk_rem)
            2'd0:    mag_digit = ibt_pkg::TRIT_NEG;
            2'd2:    mag_digit = ibt_pkg::TRIT_POS;
            default: mag_digit = ibt_pkg::TRIT_ZERO;
        endcase
    end

    assign signed_digit = r_neg ? ibt_pkg::TRIT_W'(-mag_digit) : mag_digit;
    assign slot_free    = !r_out_valid || m_axis_tready;
    assign sent_inc     = r_sent + 1'b1;
    assign out_last     = r_fixed ? (sent_inc == r_count) : r_zero;
    assign o_cmd_ready  = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_chunk     = r_chunk;
        n_div       = r_div;
        n_rem       = r_rem;
        n_zero      = r_zero;
        n_neg       = r_neg;
        n_fixed     = r_fixed;
        n_count     = r_count;
        n_sent      = r_sent;
        n_digit     = r_digit;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_trit  = r_out_trit;
        n_out_last  = r_out_last;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_neg   = i_cmd.neg;
                    n_fixed = i_cmd.fixed;
                    n_count = i_cmd.count;
                    n_sent  = '0;
                    n_div   = i_cmd.work;
                    n_rem   = '0;
                    n_chunk = '0;
                    if (i_cmd.mag_zero) begin
                        n_digit = ibt_pkg::TRIT_ZERO;
                        n_zero  = 1'b1;
                        n_state = ST_OUT;
                    end else begin
                        n_zero  = 1'b0;
                        n_state = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                n_div   = div_shift;
                n_rem   = chunk_rem;
                n_chunk = r_chunk + 1'b1;
                if (r_chunk == ibt_pkg::CHUNK_CNT_W'(ibt_pkg::NCHUNK - 1)) begin
                    // new magnitude is the quotient; keep it as quotient + 1
                    n_div   = div_shift + 1'b1;
                    n_zero  = (div_shift == '0);
                    n_digit = signed_digit;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_trit  = r_digit;
                    n_out_last  = out_last;
                    n_sent      = sent_inc;
                    if (out_last) begin
                        n_state = ST_IDLE;
                    end else if (r_zero) begin
                        n_digit = ibt_pkg::TRIT_ZERO;
                    end else begin
                        n_rem   = '0;
                        n_chunk = '0;
                        n_state = ST_DIV;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_chunk    <= n_chunk;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_zero     <= n_zero;
        r_neg      <= n_neg;
        r_fixed    <= n_fixed;
        r_count    <= n_count;
        r_sent     <= n_sent;
        r_digit    <= n_digit;
        r_out_trit <= n_out_trit;
        r_out_last <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = ibt_pkg::OUT_DATA_W'(r_out_trit);
    assign m_axis_tlast  = r_out_last;

    // dividend is magnitude + 1, never zero while dividing
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !r_zero)
        else $error("divide started on a finished magnitude");

    // fixed-length run never passes its count
    a_fixed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_fixed) |-> (r_sent < r_count))
        else $error("fixed-length run overran its count");

    // natural-length run ends within the longest possible digit string
    a_nat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && !r_fixed) |-> (r_sent < ibt_pkg::NAT_MAX_TRITS))
        else $error("natural-length run too long");

    // only the three legal trit codes leave the block
    a_trit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_trit != ibt_pkg::TRIT_BAD))
        else $error("illegal trit code on output");

endmodule

>>> rtl/core/int_to_balanced_ternary.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_balanced_ternary: signed 64-bit integer to balanced ternary trits
// Streams the trits of each request, least significant first, one per beat.
// ----------------------------------------------------------------------------
// Each request carries a signed 64-bit value and an optional fixed length;
// the block answers with one beat per trit (-1, 0, +1 as two's complement in
// the low two bits of tdata), tlast on the final trit. With tuser low the
// natural digit count is sent and zero sends nothing; with tuser high exactly
// length trits are sent (saturated at MAX_TRITS), cut off or padded with
// zeros, and a length of zero sends nothing. Each nonzero-magnitude digit
// passes through the serial divide-by-three unit (8 dividend bits per cycle
// over the 64-bit word) and is then handed to the output stage; padding
// zeros skip the divider. The widest magnitude has 41 natural digits. A
// two-entry request queue sits in front of the sequencer, so new requests
// are taken while the current one is still being converted, and a one-deep
// output register lets the sequencer run ahead of a stalled downstream by
// one trit.
// ----------------------------------------------------------------------------
module int_to_balanced_ternary #(
    parameter int MAX_TRITS = 64  // trit count cap with fixed length, 41..64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata, LSB up: value[63:0], length[70:64], zero fill [71]
    input  logic [ibt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: use_length
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata, LSB up: trit[1:0], zero fill [7:2]
    output logic [ibt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // tlast: last trit of this request
    output logic                           m_axis_tlast
);

    // front -> queue
    logic          push_valid;
    logic          push_ready;
    ibt_pkg::t_cmd push_cmd;

    // queue -> back
    logic          cmd_valid;
    logic          cmd_ready;
    ibt_pkg::t_cmd cmd;

    // Classification: sign split, magnitude + 1, count, drop of empty requests
    ibt_front #(
        .MAX_TRITS (MAX_TRITS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push_valid  (push_valid),
        .i_push_ready  (push_ready),
        .o_push_cmd    (push_cmd)
    );

    // Decouples intake from the slow digit loop
    ibt_cmd_fifo u_cmd_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (cmd_valid),
        .i_pop_ready  (cmd_ready),
        .o_pop_cmd    (cmd)
    );

    // Digit loop: serial divide by three, sign, padding, output stage
    ibt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_ready   (cmd_ready),
        .i_cmd         (cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
